// File: hw/rtl/pdss_pkg.sv
package pdss_pkg;

	localparam int MAX_STEPS_DEFAULT = 64;

	localparam int OP_W           = 2;
	localparam int STEP_INDEX_W   = 6;
	localparam int PROB_W         = 7;
	localparam int VEL_W          = 12;
	localparam int RND_W          = 7;
	localparam int SPREAD_RND_W   = 16;
	localparam int MV_W           = 13;
	localparam int AMP_W          = 14;
	localparam int STEP_COUNT_W   = 7;
	localparam int VRANGE_W       = 13;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 13;

	localparam int FACTOR_W       = 14;
	localparam int PF_W           = 21;
	localparam int PV_W           = 20;
	localparam int SPREAD_W       = 14;
	localparam int VEL_SUM_W      = 16;

	localparam int REM_STEPS      = 2;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE   = 2'd0,
		OP_ADVANCE = 2'd1,
		OP_BEAT    = 2'd2
	} op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_STEP_COUNT = 2'd0,
		CFG_MODIFIER   = 2'd1,
		CFG_VEL_RANGE  = 2'd2
	} cfg_reg_t;

	localparam logic [STEP_COUNT_W-1:0] STEP_COUNT_RESET = 7'd16;

	// The control voltage factor is mv/24 below the low threshold and
	// 100 + mv + mv/25 above the high one, the divisions by reciprocal
	// multiplication.
	localparam logic [MV_W-1:0] CV_LOW_MV  = 13'd2400;
	localparam logic [MV_W-1:0] CV_HIGH_MV = 13'd2600;
	localparam int CV_RECIP_W = 14;
	localparam logic [CV_RECIP_W-1:0] CV_LO_RECIP = 14'd2731;
	localparam logic [CV_RECIP_W-1:0] CV_HI_RECIP = 14'd10486;
	localparam int CV_LO_SHIFT = 16;
	localparam int CV_HI_SHIFT = 18;
	localparam logic [FACTOR_W-1:0] FACTOR_UNITY = 14'd100;

	localparam logic [PROB_W-1:0] PERCENT = 7'd100;

	// Division by 100 of the probability times range product.
	localparam int PCT_RECIP_W = 21;
	localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = 21'd1342178;
	localparam int PCT_SHIFT = 27;

	localparam logic signed [VEL_SUM_W-1:0] AMP_MIN = -16'sd8192;
	localparam logic signed [VEL_SUM_W-1:0] AMP_MAX = 16'sd8191;

	typedef struct packed {
		logic [PROB_W-1:0] prob;
		logic [VEL_W-1:0]  vel;
	} step_entry_t;

	typedef struct packed {
		logic                    start;
		logic [SPREAD_RND_W-1:0] dividend;
		logic [SPREAD_W-1:0]     divisor;
	} rem_req_t;

	typedef struct packed {
		logic                done;
		logic [SPREAD_W-1:0] rem;
	} rem_rsp_t;

endpackage

// File: hw/rtl/pdss_step_mem.sv
module pdss_step_mem #(
	parameter int DEPTH  = pdss_pkg::MAX_STEPS_DEFAULT,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_W-1:0]    waddr,
	input  pdss_pkg::step_entry_t wdata,
	input  logic                 re,
	input  logic [ADDR_W-1:0]    raddr,
	output pdss_pkg::step_entry_t rdata
);
	import pdss_pkg::*;

	step_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/pdss_rem.sv
module pdss_rem (
	input  logic               clk,
	input  logic               arst_n,
	input  pdss_pkg::rem_req_t req,
	output pdss_pkg::rem_rsp_t rsp
);
	import pdss_pkg::*;

	localparam int ITER  = SPREAD_RND_W / REM_STEPS;
	localparam int CNT_W = $clog2(ITER);

	logic                    busy_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [SPREAD_RND_W-1:0] dvd_q;
	logic [SPREAD_W-1:0]     div_q;
	logic [SPREAD_W-1:0]     rem_q;
	logic [SPREAD_RND_W-1:0] dvd_nxt;
	logic [SPREAD_W-1:0]     rem_nxt;

	// Restoring remainder, REM_STEPS dividend bits per cycle.
	always_comb begin
		logic [SPREAD_W:0] t;
		rem_nxt = rem_q;
		dvd_nxt = dvd_q;
		for (int i = 0; i < REM_STEPS; i++) begin
			t = {rem_nxt, dvd_nxt[SPREAD_RND_W-1]};
			dvd_nxt = dvd_nxt << 1;
			if (t >= {1'b0, div_q}) begin
				t = t - {1'b0, div_q};
			end
			rem_nxt = t[SPREAD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ITER - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

// File: hw/rtl/probability_drum_step_sequencer.sv
// Probability drum step sequencer.
// Input items arrive on in_valid/in_stall with one field per port; each item
// yields exactly one result transfer on out_valid/out_stall (fire, amplitude).
// Configuration is to be written through cfg_we/cfg_index/cfg_data while
// idle; the block itself does not enforce this. A write, a beat or an
// unused op completes in the accept cycle and its result is presented in
// the next cycle. An advance reads the step memory in the accept cycle and
// decides in S_READ with the modifier off or the step at rest, else in
// S_DECIDE; a hit with a velocity range then passes S_SCALE, S_SPREAD and
// S_START, and S_REM when the drawn spread is nonzero, before S_FINAL emits
// the result. The remainder unit retires two dividend bits per cycle over
// 16 bits. The block works on one item at a time; a finished result
// sits in the output register, and the next item is taken in the cycle
// that result transfers or later. While the receiver stalls the result
// holds unchanged. Reset clears position, the pending hit, the pending
// velocity and the registers (16 steps, modifier off, no range). The step
// memory is not cleared; steps must be written before they are reached.
module probability_drum_step_sequencer #(
	parameter int MAX_STEPS = pdss_pkg::MAX_STEPS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pdss_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pdss_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [pdss_pkg::OP_W-1:0]           op,
	input  logic [pdss_pkg::STEP_INDEX_W-1:0]   step_index,
	input  logic [pdss_pkg::PROB_W-1:0]         step_probability,
	input  logic [pdss_pkg::VEL_W-1:0]          step_velocity,
	input  logic [pdss_pkg::RND_W-1:0]          random_hit,
	input  logic [pdss_pkg::SPREAD_RND_W-1:0]   random_spread,
	input  logic [pdss_pkg::MV_W-1:0]           cv_millivolts,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                fire,
	output logic signed [pdss_pkg::AMP_W-1:0]   amplitude
);
	import pdss_pkg::*;

	localparam int POS_W     = $clog2(MAX_STEPS);
	localparam int CMP_W     = ((POS_W + 1) > STEP_COUNT_W) ? (POS_W + 1) : STEP_COUNT_W;
	localparam int IDX_CMP_W = ((POS_W + 1) > STEP_INDEX_W) ? (POS_W + 1) : STEP_INDEX_W;
	localparam int FMUL_W    = MV_W + CV_RECIP_W;
	localparam int SMUL_W    = PV_W + PCT_RECIP_W;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_READ   = 8'b0000_0010,
		S_DECIDE = 8'b0000_0100,
		S_SCALE  = 8'b0000_1000,
		S_SPREAD = 8'b0001_0000,
		S_START  = 8'b0010_0000,
		S_REM    = 8'b0100_0000,
		S_FINAL  = 8'b1000_0000
	} fsm_t;

	fsm_t state_q, state_d;

	logic [STEP_COUNT_W-1:0] step_count_q;
	logic                    mod_en_q;
	logic [VRANGE_W-1:0]     vel_range_q;

	logic [POS_W-1:0]        pos_q;
	logic                    hit_q;
	logic signed [AMP_W-1:0] pend_vel_q;

	logic [RND_W-1:0]        rnd_q;
	logic [SPREAD_RND_W-1:0] spread_rnd_q;
	logic [MV_W-1:0]         mv_q;
	logic [PROB_W-1:0]       p_q;
	logic [VEL_W-1:0]        v_q;
	logic [FACTOR_W-1:0]     factor_q;
	logic [PV_W-1:0]         pv_q;
	logic [SPREAD_W-1:0]     spread_q;
	logic [SPREAD_W-1:0]     off_q;

	logic                    out_valid_q;
	logic                    fire_q;
	logic signed [AMP_W-1:0] amp_q;

	logic                    in_accept;
	logic                    emit;
	logic                    emit_fire;
	logic signed [AMP_W-1:0] emit_amp;
	logic                    hit_we;
	logic                    hit_d;
	logic                    pvel_we;
	logic signed [AMP_W-1:0] pvel_d;
	logic                    pos_we;
	logic                    mem_we;
	logic                    mem_re;
	logic                    idx_ok;

	logic [CMP_W-1:0]        sc_ext;
	logic [CMP_W-1:0]        eff_cnt;
	logic [CMP_W-1:0]        pos_inc;
	logic [POS_W-1:0]        pos_next;

	step_entry_t             wr_entry;
	step_entry_t             rd_entry;

	logic                    cv_lo;
	logic                    cv_hi;
	logic [FMUL_W-1:0]       fac_mul;
	logic [FACTOR_W-1:0]     factor_d;
	logic [PF_W-1:0]         pf;
	logic [PF_W-1:0]         rnd_pct;
	logic                    decide_hit;
	logic [SMUL_W-1:0]       sp_mul;
	logic signed [VEL_SUM_W-1:0] vel_sum;
	logic signed [AMP_W-1:0] vel_clamped;

	rem_req_t                rem_req;
	rem_rsp_t                rem_rsp;

	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign in_accept = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign fire      = fire_q;
	assign amplitude = amp_q;

	// Position update with the step count held to 1..MAX_STEPS.
	always_comb begin
		sc_ext  = CMP_W'(step_count_q);
		pos_inc = CMP_W'(pos_q) + CMP_W'(1);
		if (sc_ext == '0) begin
			eff_cnt = CMP_W'(1);
		end else if (sc_ext > CMP_W'(MAX_STEPS)) begin
			eff_cnt = CMP_W'(MAX_STEPS);
		end else begin
			eff_cnt = sc_ext;
		end
		pos_next = (pos_inc >= eff_cnt) ? '0 : pos_inc[POS_W-1:0];
	end

	assign idx_ok        = IDX_CMP_W'(step_index) < IDX_CMP_W'(MAX_STEPS);
	assign wr_entry.prob = step_probability;
	assign wr_entry.vel  = step_velocity;

	pdss_step_mem #(
		.DEPTH  (MAX_STEPS),
		.ADDR_W (POS_W)
	) u_step_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (POS_W'(step_index)),
		.wdata (wr_entry),
		.re    (mem_re),
		.raddr (pos_next),
		.rdata (rd_entry)
	);

	always_comb begin
		cv_lo   = mv_q < CV_LOW_MV;
		cv_hi   = mv_q > CV_HIGH_MV;
		fac_mul = FMUL_W'(mv_q) * FMUL_W'(cv_lo ? CV_LO_RECIP : CV_HI_RECIP);
		if (cv_lo) begin
			factor_d = FACTOR_W'(fac_mul >> CV_LO_SHIFT);
		end else if (cv_hi) begin
			factor_d = FACTOR_UNITY + FACTOR_W'(mv_q) + FACTOR_W'(fac_mul >> CV_HI_SHIFT);
		end else begin
			factor_d = FACTOR_UNITY;
		end
	end

	// floor(p * factor / 100) >= r holds exactly when p * factor >= 100 * r.
	assign pf         = PF_W'(p_q) * PF_W'(factor_q);
	assign rnd_pct    = PF_W'(rnd_q) * PF_W'(PERCENT);
	assign decide_hit = pf >= rnd_pct;

	assign sp_mul = SMUL_W'(pv_q) * SMUL_W'(PCT_RECIP);

	always_comb begin
		vel_sum = $signed(VEL_SUM_W'(off_q)) - $signed(VEL_SUM_W'(spread_q >> 1))
			+ $signed(VEL_SUM_W'(v_q));
		if (vel_sum < AMP_MIN) begin
			vel_clamped = AMP_W'(AMP_MIN);
		end else if (vel_sum > AMP_MAX) begin
			vel_clamped = AMP_W'(AMP_MAX);
		end else begin
			vel_clamped = vel_sum[AMP_W-1:0];
		end
	end

	pdss_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	always_comb begin
		state_d          = state_q;
		emit             = 1'b0;
		emit_fire        = 1'b0;
		emit_amp         = '0;
		hit_we           = 1'b0;
		hit_d            = hit_q;
		pvel_we          = 1'b0;
		pvel_d           = pend_vel_q;
		pos_we           = 1'b0;
		mem_we           = 1'b0;
		mem_re           = 1'b0;
		rem_req.start    = 1'b0;
		rem_req.dividend = spread_rnd_q;
		rem_req.divisor  = spread_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					unique case (op)
						OP_WRITE: begin
							mem_we = idx_ok;
							emit   = 1'b1;
						end
						OP_ADVANCE: begin
							mem_re  = 1'b1;
							pos_we  = 1'b1;
							state_d = S_READ;
						end
						OP_BEAT: begin
							emit      = 1'b1;
							emit_fire = hit_q;
							emit_amp  = hit_q ? pend_vel_q : '0;
							hit_we    = 1'b1;
							hit_d     = 1'b0;
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				if (rd_entry.prob == '0) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end else if (!mod_en_q) begin
					hit_we  = 1'b1;
					hit_d   = rd_entry.prob >= rnd_q;
					pvel_we = 1'b1;
					pvel_d  = AMP_W'(rd_entry.vel);
					emit    = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				hit_we = 1'b1;
				hit_d  = decide_hit;
				if (!decide_hit) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end else if (vel_range_q == '0) begin
					pvel_we = 1'b1;
					pvel_d  = AMP_W'(v_q);
					emit    = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_SCALE;
				end
			end
			S_SCALE: begin
				state_d = S_SPREAD;
			end
			S_SPREAD: begin
				state_d = S_START;
			end
			S_START: begin
				if (spread_q == '0) begin
					state_d = S_FINAL;
				end else begin
					rem_req.start = 1'b1;
					state_d       = S_REM;
				end
			end
			S_REM: begin
				if (rem_rsp.done) begin
					state_d = S_FINAL;
				end
			end
			S_FINAL: begin
				pvel_we = 1'b1;
				pvel_d  = vel_clamped;
				emit    = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_count_q <= STEP_COUNT_RESET;
			mod_en_q     <= 1'b0;
			vel_range_q  <= '0;
			pos_q        <= '0;
			hit_q        <= 1'b0;
			pend_vel_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_STEP_COUNT: step_count_q <= cfg_data[STEP_COUNT_W-1:0];
					CFG_MODIFIER:   mod_en_q     <= cfg_data[0];
					CFG_VEL_RANGE:  vel_range_q  <= cfg_data[VRANGE_W-1:0];
					default: begin
					end
				endcase
			end
			if (pos_we) begin
				pos_q <= pos_next;
			end
			if (hit_we) begin
				hit_q <= hit_d;
			end
			if (pvel_we) begin
				pend_vel_q <= pvel_d;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			rnd_q        <= random_hit;
			spread_rnd_q <= random_spread;
			mv_q         <= cv_millivolts;
		end
		if (state_q == S_READ) begin
			p_q      <= rd_entry.prob;
			v_q      <= rd_entry.vel;
			factor_q <= factor_d;
		end
		if (state_q == S_SCALE) begin
			pv_q <= PV_W'(p_q) * PV_W'(vel_range_q);
		end
		if (state_q == S_SPREAD) begin
			spread_q <= SPREAD_W'(sp_mul >> PCT_SHIFT);
		end
		if (state_q == S_START) begin
			off_q <= '0;
		end else if ((state_q == S_REM) && rem_rsp.done) begin
			off_q <= rem_rsp.rem;
		end
		if (emit) begin
			fire_q <= emit_fire;
			amp_q  <= emit_amp;
		end
	end

endmodule
